FILE: rtl/sphere_frustum_cull_defines.svh
// assertion macros for the sphere frustum cull block
// used by the top level only; no other dependencies
`ifndef SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SFC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sfc assertion failed");

// next-cycle implication, disabled while reset is low
`define SFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sfc assertion failed");

`endif

FILE: rtl/sfc_pkg.sv
// shared constants and helpers for the sphere frustum cull block
// no dependencies; used by sphere_frustum_cull
`default_nettype none

package sfc_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DVD_W     = DW + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam logic signed [DW-1:0] Q_ONE = DW'(64'(1) << FRAC_BITS);

  // memory depths
  localparam int MAT_DEPTH = 48;
  localparam int SCR_DEPTH = 32;
  localparam int PLN_DEPTH = 24;

  // item codes
  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_SPHERE = 1'b1;
  localparam logic [1:0] MSEL_IGNORE = 2'd3;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return DW'(hi);
    end else if (v < lo) begin
      return DW'(lo);
    end
    return DW'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sphere_frustum_cull.sv
// Sphere frustum cull: matrix load and sphere test words on one input
// channel, six-bit clip flags on the output channel. Both channels use
// valid/ready; a word moves when valid and ready are high at a clock edge.
// A load word (func 0) writes one element of the projection, view or
// world matrix in the cycle it is accepted; select 3 is dropped. It gives
// no result. A sphere word (func 1) gives one result word. If any matrix
// changed since the last test, the frustum planes are first rebuilt:
// two 4x4 matrix products on the shared multiplier, then six plane
// extractions with a bit-serial square root and a bit-serial divider.
// The sphere test itself runs six planes of three multiply-accumulates,
// each a ram read, a multiply and an add. The input takes one word
// at a time; a finished result waits in an output register, so the
// next word is accepted while the receiver stalls. If the receiver
// still holds the previous result when a new one is ready, the block
// waits. Reset loads identity matrices (flags, no ram sweep) and marks
// the planes stale.
// Depends on sfc_pkg, sfc_ram and sphere_frustum_cull_defines.svh.
`default_nettype none

`include "sphere_frustum_cull_defines.svh"

module sphere_frustum_cull (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               func_i,
  input  wire logic [1:0]         matrix_select_i,
  input  wire logic [3:0]         element_index_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic signed [31:0] center_x_i,
  input  wire logic signed [31:0] center_y_i,
  input  wire logic signed [31:0] center_z_i,
  input  wire logic signed [31:0] radius_i,
  input  wire logic               last_sphere_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [5:0]         clip_flags_o,
  output      logic               last_result_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_M_RDA, S_M_RDB, S_M_MUL, S_M_ACC, S_M_WR,
    S_P_RD3, S_P_RDI, S_P_CMB, S_P_SQ, S_P_SQA, S_SQ_RUN, S_SQ_END,
    S_N_RD, S_N_LD, S_N_DIV, S_N_WR,
    S_T_RD, S_T_MUL, S_T_ACC, S_T_ADD, S_T_OUT
  } state_e;

  localparam int DW = sfc_pkg::DW;
  localparam int DVD_W = sfc_pkg::DVD_W;
  localparam int CNT_W = sfc_pkg::CNT_W;

  state_e                      state_q;
  logic                        pass_q;
  logic [1:0]                  col_q, row_q, k_q, j_q;
  logic [2:0]                  p_q;
  logic                        stale_q;
  logic [sfc_pkg::MAT_DEPTH-1:0] mvalid_q;
  logic                        mrd_vld_q, mrd_diag_q;
  logic signed [DW-1:0]        opa_q, r3_q, comp_q;
  logic signed [63:0]          prod_q, acc_q;
  logic [63:0]                 sq_q, sqn_q, sqr_q, sqb_q;
  logic [DW-1:0]               len_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [DVD_W-1:0]            dvd_q;
  logic [DW:0]                 rem_q;
  logic                        neg_q;
  logic signed [DW-1:0]        cx_q, cy_q, cz_q, r_q;
  logic                        last_q;
  logic [5:0]                  flags_q;
  logic                        out_valid_q;
  logic [5:0]                  out_flags_q;
  logic                        out_last_q;

  logic                        in_acc;
  logic                        mat_we;
  logic [5:0]                  mat_waddr, mat_raddr;
  logic signed [DW-1:0]        mat_rdata, mat_val;
  logic                        scr_we;
  logic [4:0]                  scr_waddr, scr_raddr;
  logic signed [DW-1:0]        scr_rdata, scr_wdata;
  logic                        pln_we;
  logic [4:0]                  pln_addr;
  logic signed [DW-1:0]        pln_rdata, pln_wdata;
  logic signed [DW-1:0]        mul_a, mul_b;
  logic signed [63:0]          mul_p;
  logic signed [DW:0]          comb_sum;
  logic signed [DW-1:0]        comb_v, norm_v, dist_v, cen;
  logic signed [DVD_W:0]       quot_s;
  logic [63:0]                 sq_t;
  logic                        sq_ge;
  logic [DW:0]                 rem_sh;
  logic                        div_ge;
  logic [DW-1:0]               mag;
  logic signed [DW:0]          neg_r;
  logic                        flag_v;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign clip_flags_o  = out_flags_q;
  assign last_result_o = out_last_q;

  // matrix store: load writes, identity for entries never written
  assign mat_we    = in_acc && (func_i == sfc_pkg::FUNC_LOAD) &&
                     (matrix_select_i != sfc_pkg::MSEL_IGNORE);
  assign mat_waddr = {matrix_select_i, element_index_i};
  assign mat_raddr = (state_q == S_M_RDB) ? {(pass_q ? 2'd2 : 2'd1), col_q, k_q}
                                          : {2'd0, k_q, row_q};
  assign mat_val   = mrd_vld_q ? mat_rdata : (mrd_diag_q ? sfc_pkg::Q_ONE : '0);

  sfc_ram #(.Width(DW), .Depth(sfc_pkg::MAT_DEPTH)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (element_value_i),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  // scratch: proj*view in the low half, clip matrix in the high half
  assign scr_we    = (state_q == S_M_WR);
  assign scr_waddr = {pass_q, col_q, row_q};
  assign scr_wdata = sfc_pkg::sat32(acc_q);
  always_comb begin
    case (state_q)
      S_M_RDA: scr_raddr = {1'b0, k_q, row_q};
      S_P_RD3: scr_raddr = {1'b1, j_q, 2'd3};
      default: scr_raddr = {1'b1, j_q, p_q[2:1]};
    endcase
  end

  sfc_ram #(.Width(DW), .Depth(sfc_pkg::SCR_DEPTH)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // plane store: raw components, then normalized in place
  assign pln_addr  = {p_q, j_q};
  assign pln_we    = (state_q == S_P_CMB) || (state_q == S_N_WR);
  assign pln_wdata = (state_q == S_P_CMB) ? comb_v : norm_v;

  sfc_ram #(.Width(DW), .Depth(sfc_pkg::PLN_DEPTH)) u_pln_ram (
    .clk_i   (clk_i),
    .we_i    (pln_we),
    .waddr_i (pln_addr),
    .wdata_i (pln_wdata),
    .raddr_i (pln_addr),
    .rdata_o (pln_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    case (j_q)
      2'd0:    cen = cx_q;
      2'd1:    cen = cy_q;
      default: cen = cz_q;
    endcase
    case (state_q)
      S_M_MUL: begin
        mul_a = opa_q;
        mul_b = mat_val;
      end
      S_P_SQ: begin
        mul_a = comp_q;
        mul_b = comp_q;
      end
      default: begin
        mul_a = pln_rdata;
        mul_b = cen;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // plane extraction: row3 plus or minus the axis row
  assign comb_sum = p_q[0] ? ({r3_q[DW-1], r3_q} - {scr_rdata[DW-1], scr_rdata})
                           : ({r3_q[DW-1], r3_q} + {scr_rdata[DW-1], scr_rdata});
  assign comb_v   = sfc_pkg::sat32(64'(comb_sum));

  // square root step
  assign sq_t  = sqr_q + sqb_q;
  assign sq_ge = (sqn_q >= sq_t);

  // restoring divider step and result sign
  assign rem_sh = {rem_q[DW-1:0], dvd_q[DVD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, len_q});
  assign mag    = pln_rdata[DW-1] ? DW'(-pln_rdata) : pln_rdata;
  assign quot_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign norm_v = sfc_pkg::sat32(64'(quot_s));

  // distance compare against minus radius
  assign dist_v = sfc_pkg::sat32(acc_q + 64'(pln_rdata));
  assign neg_r  = -$signed({r_q[DW-1], r_q});
  assign flag_v = ($signed({dist_v[DW-1], dist_v}) < neg_r);

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      p_q         <= '0;
      stale_q     <= 1'b1;
      mvalid_q    <= '0;
      mrd_vld_q   <= 1'b0;
      mrd_diag_q  <= 1'b0;
      opa_q       <= '0;
      r3_q        <= '0;
      comp_q      <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      sq_q        <= '0;
      sqn_q       <= '0;
      sqr_q       <= '0;
      sqb_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      r_q         <= '0;
      last_q      <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      out_flags_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      mrd_vld_q  <= mvalid_q[mat_raddr];
      mrd_diag_q <= (mat_raddr[3:2] == mat_raddr[1:0]);
      if (out_valid_q && out_ready_i && (state_q != S_T_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (func_i == sfc_pkg::FUNC_LOAD) begin
              if (mat_we) begin
                mvalid_q[mat_waddr] <= 1'b1;
                stale_q             <= 1'b1;
              end
            end else begin
              cx_q    <= center_x_i;
              cy_q    <= center_y_i;
              cz_q    <= center_z_i;
              r_q     <= radius_i;
              last_q  <= last_sphere_i;
              acc_q   <= '0;
              flags_q <= '0;
              p_q     <= '0;
              j_q     <= '0;
              if (stale_q) begin
                pass_q  <= 1'b0;
                col_q   <= '0;
                row_q   <= '0;
                k_q     <= '0;
                state_q <= S_M_RDA;
              end else begin
                state_q <= S_T_RD;
              end
            end
          end
        end
        // matrix product, each term a read of both operands, a multiply and an add
        S_M_RDA: state_q <= S_M_RDB;
        S_M_RDB: begin
          opa_q   <= pass_q ? scr_rdata : mat_val;
          state_q <= S_M_MUL;
        end
        S_M_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_M_ACC;
        end
        S_M_ACC: begin
          acc_q <= acc_q + (prod_q >>> sfc_pkg::FRAC_BITS);
          k_q   <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_M_WR : S_M_RDA;
        end
        S_M_WR: begin
          acc_q <= '0;
          row_q <= row_q + 2'd1;
          if (row_q == 2'd3) begin
            col_q <= col_q + 2'd1;
          end
          if (row_q == 2'd3 && col_q == 2'd3) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              state_q <= S_M_RDA;
            end else begin
              p_q     <= '0;
              j_q     <= '0;
              sq_q    <= '0;
              state_q <= S_P_RD3;
            end
          end else begin
            state_q <= S_M_RDA;
          end
        end
        // plane components and squared normal length
        S_P_RD3: state_q <= S_P_RDI;
        S_P_RDI: begin
          r3_q    <= scr_rdata;
          state_q <= S_P_CMB;
        end
        S_P_CMB: begin
          comp_q <= comb_v;
          if (j_q == 2'd3) begin
            sqn_q   <= sq_q;
            sqr_q   <= '0;
            sqb_q   <= 64'(1) << 62;
            cnt_q   <= '0;
            state_q <= S_SQ_RUN;
          end else begin
            state_q <= S_P_SQ;
          end
        end
        S_P_SQ: begin
          prod_q  <= mul_p;
          state_q <= S_P_SQA;
        end
        S_P_SQA: begin
          sq_q    <= sq_q + prod_q;
          j_q     <= j_q + 2'd1;
          state_q <= S_P_RD3;
        end
        // integer square root, two bits of radicand per cycle
        S_SQ_RUN: begin
          if (sq_ge) begin
            sqn_q <= sqn_q - sq_t;
            sqr_q <= (sqr_q >> 1) + sqb_q;
          end else begin
            sqr_q <= sqr_q >> 1;
          end
          sqb_q <= sqb_q >> 2;
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(31)) begin
            state_q <= S_SQ_END;
          end
        end
        S_SQ_END: begin
          len_q <= sqr_q[DW-1:0];
          j_q   <= '0;
          if (sqr_q != '0) begin
            state_q <= S_N_RD;
          end else begin
            sq_q <= '0;
            if (p_q == 3'd5) begin
              stale_q <= 1'b0;
              p_q     <= '0;
              acc_q   <= '0;
              state_q <= S_T_RD;
            end else begin
              p_q     <= p_q + 3'd1;
              state_q <= S_P_RD3;
            end
          end
        end
        // normalize each component, one quotient bit per cycle
        S_N_RD: state_q <= S_N_LD;
        S_N_LD: begin
          neg_q   <= pln_rdata[DW-1];
          dvd_q   <= {mag, {sfc_pkg::FRAC_BITS{1'b0}}};
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_N_DIV;
        end
        S_N_DIV: begin
          rem_q <= div_ge ? (rem_sh - {1'b0, len_q}) : rem_sh;
          dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DVD_W - 1)) begin
            state_q <= S_N_WR;
          end
        end
        S_N_WR: begin
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            sq_q <= '0;
            if (p_q == 3'd5) begin
              stale_q <= 1'b0;
              p_q     <= '0;
              acc_q   <= '0;
              state_q <= S_T_RD;
            end else begin
              p_q     <= p_q + 3'd1;
              state_q <= S_P_RD3;
            end
          end else begin
            state_q <= S_N_RD;
          end
        end
        // sphere test, plane by plane
        S_T_RD: state_q <= (j_q == 2'd3) ? S_T_ADD : S_T_MUL;
        S_T_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_T_ACC;
        end
        S_T_ACC: begin
          acc_q   <= acc_q + (prod_q >>> sfc_pkg::FRAC_BITS);
          j_q     <= j_q + 2'd1;
          state_q <= S_T_RD;
        end
        S_T_ADD: begin
          flags_q[p_q] <= flag_v;
          acc_q        <= '0;
          j_q          <= '0;
          if (p_q == 3'd5) begin
            state_q <= S_T_OUT;
          end else begin
            p_q     <= p_q + 3'd1;
            state_q <= S_T_RD;
          end
        end
        S_T_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_flags_q <= flags_q;
            out_last_q  <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stale planes force a rebuild before a test
  `SFC_ASSERT_NEXT(a_stale_rebuild, clk_i, rst_ni,
    in_acc && func_i == sfc_pkg::FUNC_SPHERE && stale_q, state_q == S_M_RDA)
  // the test phase only runs on fresh planes
  `SFC_ASSERT_NOW(a_test_fresh, clk_i, rst_ni, state_q == S_T_RD, !stale_q)
  // a pending result is never overwritten
  `SFC_ASSERT_NEXT(a_no_overwrite, clk_i, rst_ni,
    state_q == S_T_OUT && out_valid_q && !out_ready_i, state_q == S_T_OUT)

endmodule

`default_nettype wire

FILE: rtl/sfc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module sfc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
